FILE: rtl/sjisfa_pkg.sv
// Shared constants and types for the Shift-JIS to bitmap font address unit.
// No dependencies.
`timescale 1ns / 1ps

package sjisfa_pkg;

   // Full-width space glyph (index 16).
   localparam logic [15:0] SPACE_ADDR = 16'd128;

   localparam logic [15:0] CODE_BASE       = 16'h8140;
   localparam logic [15:0] PLAIN_LO        = 16'h8140;
   localparam logic [15:0] PLAIN_HI        = 16'h88FC;
   localparam logic [15:0] KANJI1_LO       = 16'h8940;
   localparam logic [15:0] KANJI1_HI       = 16'h9FFC;
   localparam logic [15:0] KANJI2_LO       = 16'hE040;
   localparam logic [15:0] KANJI2_HI       = 16'hEAA4;
   localparam logic [15:0] KANJI_OFFSET    = 16'd836;
   localparam logic [15:0] KANJI_HI_OFFSET = 16'd12032;
   localparam logic [7:0]  KANJI_LEAD_BASE = 8'h88;

   localparam int NUM_SPANS = 11;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] sub;  // two's complement, subtracted modulo 2^16
   } span_type;

   // Non-kanji sub-ranges: index = (code - 0x8140) - sub
   localparam span_type PLAIN_SPANS [NUM_SPANS] = '{
      '{lo: 16'h8140, hi: 16'h817E, sub: 16'hFFF0},
      '{lo: 16'h8180, hi: 16'h81FC, sub: 16'hFFF1},
      '{lo: 16'h824F, hi: 16'h8279, sub: 16'd52},
      '{lo: 16'h8281, hi: 16'h82F1, sub: 16'd53},
      '{lo: 16'h8340, hi: 16'h837E, sub: 16'd120},
      '{lo: 16'h8380, hi: 16'h83D6, sub: 16'd121},
      '{lo: 16'h8440, hi: 16'h847E, sub: 16'd188},
      '{lo: 16'h8480, hi: 16'h84BE, sub: 16'd189},
      '{lo: 16'h8740, hi: 16'h877E, sub: 16'd768},
      '{lo: 16'h8780, hi: 16'h879C, sub: 16'd769},
      '{lo: 16'h889F, hi: 16'h88FC, sub: 16'd837}
   };

endpackage

FILE: rtl/sjisfa_addr_calc.sv
// Combinational glyph address calculation for one Shift-JIS code.
// Depends on sjisfa_pkg.
`timescale 1ns / 1ps

module sjisfa_addr_calc (
   input  logic [7:0]  lead_byte,
   input  logic [7:0]  trail_byte,
   output logic [15:0] glyph_byte_address
);

   logic [15:0] code;
   logic [15:0] rel;
   logic        lead_ok;
   logic        in_plain;
   logic        in_kanji;
   logic        trail_ok;
   logic        span_hit;
   logic [15:0] span_idx;
   logic [7:0]  d;
   logic [15:0] d_ext;
   logic [15:0] d_x68;
   logic [15:0] kanji_idx;
   logic [15:0] idx;
   logic        use_space;

   assign code = {lead_byte, trail_byte};
   assign rel  = code - sjisfa_pkg::CODE_BASE;

   always_comb begin
      lead_ok  = (lead_byte inside {[8'h81:8'h9F], [8'hE0:8'hEF]});
      in_plain = (code inside {[sjisfa_pkg::PLAIN_LO:sjisfa_pkg::PLAIN_HI]});
      in_kanji = (code inside {[sjisfa_pkg::KANJI1_LO:sjisfa_pkg::KANJI1_HI],
                               [sjisfa_pkg::KANJI2_LO:sjisfa_pkg::KANJI2_HI]});
      trail_ok = (trail_byte inside {[8'h40:8'h7E], [8'h80:8'hFC]});
   end

   // Sub-ranges are disjoint, so hits are OR-combined.
   always_comb begin
      span_hit = 1'b0;
      span_idx = '0;
      for (int i = 0; i < sjisfa_pkg::NUM_SPANS; i++) begin
         if (code >= sjisfa_pkg::PLAIN_SPANS[i].lo && code <= sjisfa_pkg::PLAIN_SPANS[i].hi) begin
            span_hit = 1'b1;
            span_idx = span_idx | (rel - sjisfa_pkg::PLAIN_SPANS[i].sub);
         end
      end
   end

   // Kanji: rel - 836 - 68*d - (trail >= 0x80) - (second block ? 12032 : 0)
   assign d         = lead_byte - sjisfa_pkg::KANJI_LEAD_BASE;
   assign d_ext     = {8'h00, d};
   assign d_x68     = (d_ext << 6) + (d_ext << 2);
   assign kanji_idx = rel - sjisfa_pkg::KANJI_OFFSET - d_x68 - {15'd0, trail_byte[7]}
                      - (lead_byte[6] ? sjisfa_pkg::KANJI_HI_OFFSET : 16'd0);

   always_comb begin
      use_space = 1'b1;
      idx       = span_idx;
      if (lead_ok && in_plain && span_hit) begin
         use_space = 1'b0;
      end else if (lead_ok && in_kanji && trail_ok) begin
         use_space = 1'b0;
         idx       = kanji_idx;
      end
      glyph_byte_address = use_space ? sjisfa_pkg::SPACE_ADDR : {idx[12:0], 3'b000};
   end

endmodule

FILE: rtl/sjis_to_bitmap_font_address_unit.sv
// Top level: Shift-JIS code to 8x8 font ROM byte address, two-register pipeline.
// Depends on sjisfa_pkg and sjisfa_addr_calc.
`timescale 1ns / 1ps

// Channel   Dir  Bus                     Contents
// req_      in   tvalid/tready/tdata16   [7:0] lead_byte, [15:8] trail_byte
// rsp_      out  tvalid/tready/tdata16   [15:0] glyph_byte_address
//
// One request per cycle sustained while rsp_tready is high. The request lands
// in the input register, the address is computed in one combinational pass
// and captured in the result register, which drives rsp_.
// reset (synchronous, active high) empties both registers.
// A stalled result holds the pipe; each register reloads as soon as the one
// after it is empty or moving, so no request is lost or doubled.

module sjis_to_bitmap_font_address_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] lead_byte, [15:8] trail_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] glyph_byte_address
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  lead_ff;
   logic [7:0]  trail_ff;
   // result register
   logic        out_valid_ff;
   logic [15:0] addr_ff;

   logic        out_load;
   logic        in_load;
   logic [15:0] addr_in;

   // Result register takes a new value when empty or being drained.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign in_load    = !in_valid_ff || out_load;
   assign req_tready = in_load;

   sjisfa_addr_calc u_calc (
      .lead_byte          (lead_ff),
      .trail_byte         (trail_ff),
      .glyph_byte_address (addr_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         lead_ff  <= req_tdata[7:0];
         trail_ff <= req_tdata[15:8];
      end
      if (out_load && in_valid_ff) begin
         addr_ff <= addr_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = addr_ff;

endmodule

FILE: rtl/sjisfa_checker.sv
// Port-level checks for the Shift-JIS font address unit, bound to the top level.
// Depends on sjis_to_bitmap_font_address_unit.
`timescale 1ns / 1ps

module sjisfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Addresses are always glyph aligned.
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] == 3'b000))
      else $error("rsp address not 8-byte aligned");

   // Pipe is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp changed while stalled");

   // With the output draining, the input side never stalls.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp ready");

endmodule

bind sjis_to_bitmap_font_address_unit sjisfa_checker u_sjisfa_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for sjis_to_bitmap_font_address_unit: random and directed
// Shift-JIS codes in, glyph ROM byte addresses checked against an in-bench predictor.
// Depends on the RTL only (rtl/sjisfa_pkg.sv, rtl/sjisfa_addr_calc.sv, top level, checker).
`timescale 1ns / 1ps

module tb_top;

   localparam logic [15:0] SPACE_GLYPH_ADDR = 16'd128;
   localparam int          NUM_RANDOM       = 1500;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          MAX_PRINTED      = 20;

   // One character request waiting for the driver
   typedef struct {
      logic [7:0] lead;
      logic [7:0] trail;
      int         gap;        // idle cycles before this request is offered
      bit         wait_idle;  // hold until every outstanding address has come back
   } char_req_type;

   // One address still owed by the block
   typedef struct {
      logic [7:0]  lead;
      logic [7:0]  trail;
      logic [15:0] addr;
   } glyph_exp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] lead_byte, [15:8] trail_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] glyph_byte_address

   char_req_type  char_req_q [$];
   glyph_exp_type glyph_addr_q [$];

   int mismatch_count = 0;
   int accepted_reqs  = 0;
   int received_addrs = 0;
   int space_addrs    = 0;
   int long_holds     = 0;
   int drain_pauses   = 0;

   sjis_to_bitmap_font_address_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Address predictor
   // Non-kanji area: a handful of sub-ranges, each with its own index offset.
   // Kanji blocks: per-lead formula that squeezes out trail 0x7F and 0xFD..0x3F.
   // Anything else lands on the full-width space glyph.
   // ---------------------------------------------------------------------------
   function automatic logic [15:0] calc_glyph_addr(input logic [7:0] lead,
                                                   input logic [7:0] trail);
      logic [15:0] code;
      int          idx;
      int          sub;
      int          d;
      bit          hit;
      code = {lead, trail};
      hit  = 1'b1;
      if (lead == 8'h00)
         return SPACE_GLYPH_ADDR;
      if (!((lead >= 8'h81 && lead <= 8'h9F) || (lead >= 8'hE0 && lead <= 8'hEF)))
         return SPACE_GLYPH_ADDR;
      if (code >= 16'h8140 && code <= 16'h88FC) begin
         if      (code >= 16'h8140 && code <= 16'h817E) sub = -16;
         else if (code >= 16'h8180 && code <= 16'h81FC) sub = -15;
         else if (code >= 16'h824F && code <= 16'h8279) sub = 52;
         else if (code >= 16'h8281 && code <= 16'h82F1) sub = 53;
         else if (code >= 16'h8340 && code <= 16'h837E) sub = 120;
         else if (code >= 16'h8380 && code <= 16'h83D6) sub = 121;
         else if (code >= 16'h8440 && code <= 16'h847E) sub = 188;
         else if (code >= 16'h8480 && code <= 16'h84BE) sub = 189;
         else if (code >= 16'h8740 && code <= 16'h877E) sub = 768;
         else if (code >= 16'h8780 && code <= 16'h879C) sub = 769;
         else if (code >= 16'h889F && code <= 16'h88FC) sub = 837;
         else hit = 1'b0;
         if (!hit)
            return SPACE_GLYPH_ADDR;
         idx = int'(code) - 'h8140 - sub;
         return {idx[12:0], 3'b000};   // idx * 8, mod 2^16
      end
      if ((code >= 16'h8940 && code <= 16'h9FFC) || (code >= 16'hE040 && code <= 16'hEAA4)) begin
         if (trail < 8'h40 || trail > 8'hFC || trail == 8'h7F)
            return SPACE_GLYPH_ADDR;
         d   = int'(lead) - 'h88;
         idx = int'(code) - 'h8140 - 836 - 68 * d;
         if (trail >= 8'h80)
            idx = idx - 1;
         if (lead >= 8'hE0)
            idx = idx - 12032;
         return {idx[12:0], 3'b000};
      end
      return SPACE_GLYPH_ADDR;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic add_char(input logic [7:0] lead, input logic [7:0] trail,
                           input int gap, input bit wait_idle);
      char_req_type c;
      c.lead      = lead;
      c.trail     = trail;
      c.gap       = gap;
      c.wait_idle = wait_idle;
      char_req_q.push_back(c);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers queued requests, predicts on acceptance.
   // ---------------------------------------------------------------------------
   char_req_type  drv_req;
   glyph_exp_type drv_exp;
   int            drv_idle = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         drv_idle   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            drv_exp.lead  = req_tdata[7:0];
            drv_exp.trail = req_tdata[15:8];
            drv_exp.addr  = calc_glyph_addr(req_tdata[7:0], req_tdata[15:8]);
            glyph_addr_q.push_back(drv_exp);
            accepted_reqs++;
         end
         if (!req_tvalid || req_tready) begin
            if (drv_idle != 0) begin
               drv_idle   <= drv_idle - 1;
               req_tvalid <= 1'b0;
            end else if (char_req_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (char_req_q[0].wait_idle && glyph_addr_q.size() != 0) begin
               // pause until the pipe has fully drained
               req_tvalid <= 1'b0;
            end else begin
               drv_req = char_req_q.pop_front();
               if (drv_req.wait_idle)
                  drain_pauses++;
               req_tvalid <= 1'b1;
               req_tdata  <= {drv_req.trail, drv_req.lead};
               drv_idle   <= (char_req_q.size() != 0) ? char_req_q[0].gap : 0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver backpressure: random stalls, bursts of steady ready, and two long
   // holds that fill the pipe and push back on the request side.
   // ---------------------------------------------------------------------------
   int  hold_left  = 0;
   int  burst_left = 0;
   bit  hold_a_done = 1'b0;
   bit  hold_b_done = 1'b0;
   int  rdy_roll;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         burst_left <= 0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_a_done && accepted_reqs >= 400) begin
         hold_a_done <= 1'b1;
         hold_left   <= LONG_HOLD_CYCLES;
         long_holds++;
         rsp_tready  <= 1'b0;
      end else if (!hold_b_done && accepted_reqs >= 1100) begin
         hold_b_done <= 1'b1;
         hold_left   <= LONG_HOLD_CYCLES;
         long_holds++;
         rsp_tready  <= 1'b0;
      end else if (burst_left != 0) begin
         burst_left <= burst_left - 1;
         rsp_tready <= 1'b1;
      end else begin
         rdy_roll = $urandom_range(0, 99);
         if (rdy_roll < 8) begin
            burst_left <= $urandom_range(20, 80);
            rsp_tready <= 1'b1;
         end else if (rdy_roll < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            hold_left  <= pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: each address against the oldest prediction.
   // ---------------------------------------------------------------------------
   glyph_exp_type mon_exp;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (glyph_addr_q.size() == 0) begin
            report_mismatch($sformatf("address %h with no request outstanding", rsp_tdata));
         end else begin
            mon_exp = glyph_addr_q.pop_front();
            received_addrs++;
            if (mon_exp.addr == SPACE_GLYPH_ADDR)
               space_addrs++;
            if (rsp_tdata !== mon_exp.addr)
               report_mismatch($sformatf("code %h%h: glyph_byte_address %h, predicted %h",
                                         mon_exp.lead, mon_exp.trail, rsp_tdata,
                                         mon_exp.addr));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   logic [15:0] boundary_codes [$] = '{
      16'h8140, 16'h817E, 16'h8180, 16'h81FC, 16'h824F, 16'h8279, 16'h8281, 16'h82F1,
      16'h8340, 16'h837E, 16'h8380, 16'h83D6, 16'h8440, 16'h847E, 16'h8480, 16'h84BE,
      16'h8740, 16'h877E, 16'h8780, 16'h879C, 16'h889F, 16'h88FC, 16'h8940, 16'h897F,
      16'h89FC, 16'h9F40, 16'h9FFC, 16'hE040, 16'hE07F, 16'hEAA4, 16'hEF40, 16'hA040
   };

   int          n;
   int          kind;
   int          burst_run;
   logic [15:0] pick;
   logic [7:0]  lead;
   logic [7:0]  trail;

   initial begin
      // directed: range edges, gaps, trail 0x7F, bad trails, out-of-range leads
      add_char(8'h00, 8'h00, 0, 0);   // no character
      add_char(8'h00, 8'hFF, 0, 0);
      add_char(8'hFF, 8'hFF, 0, 0);   // single-byte lead
      add_char(8'h80, 8'h40, 0, 0);
      add_char(8'hA0, 8'h40, 0, 0);
      add_char(8'hF0, 8'h40, 0, 0);
      add_char(8'h81, 8'h40, 0, 0);   // first symbol
      add_char(8'h81, 8'h7F, 0, 0);   // gap in symbols
      add_char(8'h81, 8'h80, 0, 0);
      add_char(8'h81, 8'hFC, 0, 0);
      add_char(8'h82, 8'h4E, 0, 0);   // gap before digits
      add_char(8'h82, 8'h4F, 0, 0);
      add_char(8'h83, 8'hD6, 0, 0);
      add_char(8'h87, 8'h9C, 0, 0);   // row 13 end
      add_char(8'h88, 8'h9E, 0, 0);
      add_char(8'h88, 8'hFC, 0, 0);
      add_char(8'h89, 8'h40, 0, 0);   // first kanji
      add_char(8'h89, 8'h7F, 0, 0);   // trail 0x7F in kanji
      add_char(8'h93, 8'h3F, 0, 0);   // trail too low
      add_char(8'h93, 8'hFD, 0, 0);   // trail too high
      add_char(8'h9F, 8'hFC, 0, 0);
      add_char(8'hE0, 8'h40, 0, 0);
      add_char(8'hEA, 8'hA4, 0, 0);   // last covered code
      add_char(8'hEA, 8'hA5, 0, 0);
      add_char(8'hEF, 8'h80, 0, 0);   // valid lead, uncovered

      burst_run = 0;
      for (n = 0; n < NUM_RANDOM; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            // kanji with in-range trail (0x7F included)
            lead  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range('hE0, 'hEA))
                                               : 8'($urandom_range('h89, 'h9F));
            trail = 8'($urandom_range('h40, 'hFC));
         end else if (kind < 55) begin
            lead  = 8'($urandom_range('h81, 'h88));
            trail = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range('h40, 'hFC));
         end else if (kind < 65) begin
            lead  = 8'($urandom_range('h81, 'h9F));
            trail = 8'($urandom);
         end else if (kind < 73) begin
            lead  = 8'($urandom_range('hE0, 'hEF));
            trail = 8'($urandom);
         end else if (kind < 85) begin
            pick  = boundary_codes[$urandom_range(0, boundary_codes.size() - 1)];
            pick  = pick + 16'($urandom_range(0, 2)) - 16'd1;
            lead  = pick[15:8];
            trail = pick[7:0];
         end else if (kind < 90) begin
            lead  = 8'h00;
            trail = 8'($urandom);
         end else begin
            lead  = 8'($urandom);
            trail = 8'($urandom);
         end
         // runs of back-to-back requests between gappy stretches
         if (burst_run == 0 && $urandom_range(0, 49) == 0)
            burst_run = $urandom_range(30, 120);
         if (burst_run != 0)
            burst_run--;
         add_char(lead, trail, (burst_run != 0) ? 0 : pick_gap(),
                  (n == 800) || ($urandom_range(0, 199) == 0));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (char_req_q.size() != 0 || req_tvalid || glyph_addr_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d glyph addresses (%0d of them the space glyph) from %0d requests.",
               received_addrs, space_addrs, accepted_reqs);
      $display("Receiver long holds: %0d, drain pauses on the request side: %0d.",
               long_holds, drain_pauses);
      if (mismatch_count == 0)
         $display("sjis_to_bitmap_font_address_unit regression: pass");
      else
         $display("sjis_to_bitmap_font_address_unit regression: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Timed out with %0d requests unsent, %0d addresses outstanding.",
               char_req_q.size(), glyph_addr_q.size());
      $display("sjis_to_bitmap_font_address_unit regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sjisfa_pkg.sv
rtl/sjisfa_addr_calc.sv
rtl/sjis_to_bitmap_font_address_unit.sv
rtl/sjisfa_checker.sv
dv/tb_top.sv
